### rtl/ssrch_pkg.sv
// Shared types and constants for the Shift-And substring search core
package ssrch_pkg;

    localparam int PATTERN_MAX_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam int SYM_W   = 7;
    localparam int IDX_W   = 5;
    localparam int LEN_W   = 6;
    localparam int START_W = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef enum logic [0:0] {
        OP_LOAD,
        OP_TEXT
    } op_kind_t;

    typedef struct packed {
        logic             cmd;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] pattern_index;
        logic             last_of_text;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_position;
        logic               position_overflow;
    } out_word_t;

    // classified word held in the queue between front and back ends
    typedef struct packed {
        op_kind_t         kind;
        logic             store_en;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] index;
        logic             last;
    } cmd_word_t;

endpackage

### rtl/ssrch_front.sv
// Front end: accepts input words, classifies them and queues them for the back end
module ssrch_front
    import ssrch_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      q_valid,
    output cmd_word_t q_word,
    input  logic      q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_word_t        queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_word_t        cls_word;
    logic             push;

    // decode the incoming word
    always_comb
    begin
        cls_word.symbol   = in_data.symbol;
        cls_word.index    = in_data.pattern_index;
        cls_word.last     = in_data.last_of_text;
        cls_word.store_en = 1'b0;
        unique case (in_data.cmd)
            CMD_LOAD:
            begin
                cls_word.kind     = OP_LOAD;
                cls_word.store_en = (int'(in_data.pattern_index) < PATTERN_MAX);
            end
            CMD_TEXT:
            begin
                cls_word.kind = OP_TEXT;
            end
            default:
            begin
                cls_word.kind = OP_TEXT;
            end
        endcase
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_word   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls_word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on push");

endmodule

### rtl/ssrch_back.sv
// Back end: pattern store, Shift-And update and result register
module ssrch_back
    import ssrch_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             q_valid,
    input  cmd_word_t        q_word,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data
);

    localparam int SA_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_EXT_W = LEN_W + 1;
    localparam int CW        = (POSITION_BITS > LEN_EXT_W) ? POSITION_BITS : LEN_EXT_W;
    localparam int SW        = (CW > START_W) ? CW : START_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_EXT_W-1:0]     LEN_CAP = LEN_EXT_W'(PATTERN_MAX);

    logic [SYM_W-1:0]         store_reg [PATTERN_MAX];
    logic [LEN_W-1:0]         len_reg;
    logic [PATTERN_MAX-1:0]   vec_reg, vec_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     sat_reg, sat_next;
    logic                     reported_reg, reported_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_data_reg, out_data_next;

    logic [LEN_EXT_W-1:0]     len_ext, len_eff, back_len;
    logic [PATTERN_MAX-1:0]   mask, tap, vec_new;
    logic                     hit;
    logic [CW-1:0]            pos_ext, back_ext, diff;
    logic [SW-1:0]            start_ext;
    logic                     take, emit, store_we;
    logic [SA_W-1:0]          wr_addr;

    // effective length: zero reads as one, capped at the store depth
    always_comb
    begin
        len_ext = {1'b0, len_reg};
        if (len_ext == '0)
        begin
            len_eff = LEN_EXT_W'(1);
        end
        else if (len_ext > LEN_CAP)
        begin
            len_eff = LEN_CAP;
        end
        else
        begin
            len_eff = len_ext;
        end
        back_len = len_eff - LEN_EXT_W'(1);
    end

    // character mask and match tap, one comparator per pattern position
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            mask[j] = (j < int'(len_eff)) && (store_reg[j] == q_word.symbol);
            tap[j]  = (j == int'(back_len));
        end
        vec_new = ((vec_reg << 1) | PATTERN_MAX'(1)) & mask;
        hit     = |(vec_new & tap);
    end

    // start of match, floored at zero when the position is below the pattern length less one
    always_comb
    begin
        pos_ext   = CW'(pos_reg);
        back_ext  = CW'(back_len);
        diff      = (pos_ext >= back_ext) ? pos_ext - back_ext : '0;
        start_ext = SW'(diff);
    end

    assign take     = q_valid && (!out_valid_reg || out_ready);
    assign q_pop    = take;
    assign store_we = take && (q_word.kind == OP_LOAD) && q_word.store_en;
    assign wr_addr  = SA_W'(q_word.index);

    always_comb
    begin
        vec_next       = vec_reg;
        pos_next       = pos_reg;
        sat_next       = sat_reg;
        reported_next  = reported_reg;
        emit           = 1'b0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (take && (q_word.kind == OP_TEXT))
        begin
            if (!reported_reg)
            begin
                vec_next = vec_new;
                if (hit)
                begin
                    emit                            = 1'b1;
                    reported_next                   = 1'b1;
                    out_data_next.found             = 1'b1;
                    out_data_next.start_position    = start_ext[START_W-1:0];
                    out_data_next.position_overflow = sat_reg;
                end
                else if (q_word.last)
                begin
                    emit                            = 1'b1;
                    out_data_next.found             = 1'b0;
                    out_data_next.start_position    = '0;
                    out_data_next.position_overflow = sat_reg;
                end
                if (pos_reg == POS_MAX)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
            end
            if (q_word.last)
            begin
                vec_next      = '0;
                pos_next      = '0;
                sat_next      = 1'b0;
                reported_next = 1'b0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            vec_reg       <= '0;
            pos_reg       <= '0;
            sat_reg       <= 1'b0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            vec_reg       <= vec_next;
            pos_reg       <= pos_next;
            sat_reg       <= sat_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (store_we)
        begin
            store_reg[wr_addr] <= q_word.symbol;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> pos_reg == POS_MAX)
        else $error("saturation flag set below counter maximum");

    a_hold_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        take && (q_word.kind == OP_TEXT) && reported_reg && !q_word.last
        |=> reported_reg && $stable(pos_reg) && $stable(vec_reg))
        else $error("text state moved after a reported match");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || out_ready)
        else $error("result overwrote a pending word");

endmodule

### rtl/shift_and_substring_search_core.sv
// Top level of the Shift-And exact substring search core
// Bit-parallel Shift-And matcher over 7-bit characters. Load words (cmd 0) write one
// pattern character each; text words (cmd 1) advance the match vector, and the first
// match in a text yields one result word with found set and the zero-based start
// index. A text word with last_of_text closes the text, yielding found clear if
// nothing matched, and resets the text state. Throughput is one word per clock,
// sustained while the output is not stalled: the front end queues up to four
// classified words and the back end performs the whole mask-shift-and update and
// result formation combinationally, so a result word is registered once its input
// word is taken from the queue. The index counter saturates and the
// overflow flag is reported with the result. pattern_length may only be changed
// while no words are in flight; a length of zero acts as one.
module shift_and_substring_search_core
    import ssrch_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data
);

    logic      q_valid;
    logic      q_pop;
    cmd_word_t q_word;

    ssrch_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    ssrch_back #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### tb/shift_and_substring_search_core_test.sv
// Self-checking regression for the Shift-And substring search core
`timescale 1ns / 100ps

module shift_and_substring_search_core_test;
    import ssrch_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_CYCLES = 8;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_word_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_word_t        out_data;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_data;

    // matcher state as the testbench sees it
    logic [SYM_W-1:0]         pat_store [PATTERN_MAX_DEF];
    logic [PATTERN_MAX_DEF-1:0] match_vec;
    logic [START_W-1:0]       text_pos;
    logic                     saturated;
    logic                     reported;
    logic [LEN_W-1:0]         cur_len;
    out_word_t                pending_verdicts [$];

    int send_idle_pct;
    int recv_idle_pct;
    int ready_hold;
    int items_sent;
    int results_checked;
    int error_count;
    int settings_used;
    int stall_cycles;
    int cycle_count;

    shift_and_substring_search_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("shift_and_substring_search_core regression: fail");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned used_length(input logic [LEN_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > PATTERN_MAX_DEF)
            return PATTERN_MAX_DEF;
        return v;
    endfunction

    task automatic search_step(input in_word_t w);
        int unsigned len;
        logic [PATTERN_MAX_DEF-1:0] mask;
        out_word_t r;
        if (w.cmd == CMD_LOAD)
        begin
            pat_store[w.pattern_index] = w.symbol;
            return;
        end
        if (!reported)
        begin
            len = used_length(cur_len);
            mask = '0;
            for (int j = 0; j < len; j++)
                if (pat_store[j] == w.symbol)
                    mask[j] = 1'b1;
            match_vec = ((match_vec << 1) | 1) & mask;
            r.position_overflow = saturated;
            if (match_vec[len-1])
            begin
                r.found = 1'b1;
                r.start_position = (text_pos >= len - 1) ? text_pos - START_W'(len - 1) : '0;
                reported = 1'b1;
                pending_verdicts.push_back(r);
            end
            else if (w.last_of_text)
            begin
                r.found = 1'b0;
                r.start_position = '0;
                pending_verdicts.push_back(r);
            end
            if (text_pos == '1)
                saturated = 1'b1;
            else
                text_pos++;
        end
        if (w.last_of_text)
        begin
            match_vec = '0;
            text_pos = '0;
            saturated = 1'b0;
            reported = 1'b0;
        end
    endtask

    // predict on every accepted word, then check every accepted result
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                search_step(in_data);
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_verdicts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: found=%0b start=%0d ovf=%0b",
                                 out_data.found, out_data.start_position,
                                 out_data.position_overflow);
                end
                else
                begin
                    exp_w = pending_verdicts.pop_front();
                    if (out_data.found !== exp_w.found
                        || out_data.start_position !== exp_w.start_position
                        || out_data.position_overflow !== exp_w.position_overflow)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("result %0d: expected found=%0b start=%0d ovf=%0b",
                                     results_checked, exp_w.found, exp_w.start_position,
                                     exp_w.position_overflow);
                            $display("result %0d: got found=%0b start=%0d ovf=%0b",
                                     results_checked, out_data.found,
                                     out_data.start_position, out_data.position_overflow);
                        end
                    end
                end
            end
        end
    end

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(posedge clk);
            if (!in_ready)
                stall_cycles++;
        end
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_load(input int idx, input int sym);
        in_word_t w;
        w.cmd = CMD_LOAD;
        w.symbol = SYM_W'(sym);
        w.pattern_index = IDX_W'(idx);
        w.last_of_text = 1'($urandom);
        send_word(w);
    endtask

    task automatic send_text(input int sym, input bit last);
        in_word_t w;
        w.cmd = CMD_TEXT;
        w.symbol = SYM_W'(sym);
        w.pattern_index = IDX_W'($urandom);
        w.last_of_text = last;
        send_word(w);
    endtask

    // small alphabet half the time so that patterns repeat characters
    function automatic int pick_symbol();
        if ($urandom_range(1))
            return $urandom_range(127);
        return 8'h41 + $urandom_range(2);
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_len = v;
        settings_used++;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // length 1 from reset
        send_load(0, 8'h7F);
        send_load(31, 8'h00);
        send_text(8'h00, 1'b0);
        send_text(8'h7F, 1'b0);        // found, start 1
        send_text(8'h7F, 1'b0);        // ignored after the match
        send_text(8'h12, 1'b1);        // closes silently
        send_text(8'h7F, 1'b1);        // match on the last character
        send_text(8'h05, 1'b1);        // not found
        write_length(3);
        send_load(0, 8'h61);
        send_load(1, 8'h62);
        send_load(2, 8'h63);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h63, 1'b0);        // found, start 2
        send_text(8'h78, 1'b1);
        send_text(8'h61, 1'b0);
        send_load(2, 8'h64);           // pattern rewritten mid-text
        send_text(8'h62, 1'b0);
        send_text(8'h64, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);        // text too short, not found
    endtask

    task automatic send_random_text();
        int unsigned len;
        int kind;
        int n;
        int syms [$];
        len = used_length(cur_len);
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 4)) send_load($urandom_range(31), pick_symbol());
            return;
        end
        if (kind < 62)
        begin
            repeat ($urandom_range(0, 5)) syms.push_back(pat_store[$urandom_range(len - 1)]);
            for (int j = 0; j < len; j++)
                syms.push_back(pat_store[j]);
            repeat ($urandom_range(0, 3)) syms.push_back(pick_symbol());
        end
        else if (kind < 87)
        begin
            n = $urandom_range(1, len + 4);
            repeat (n) syms.push_back(pat_store[$urandom_range(len - 1)]);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) syms.push_back($urandom_range(127));
        end
        foreach (syms[i])
        begin
            if ($urandom_range(99) < 4)
                send_load($urandom_range(31), pick_symbol());
            send_text(syms[i], i == syms.size() - 1);
        end
    endtask

    task automatic test_random_traffic(input int s_idle, input int r_idle, input int quota);
        logic [LEN_W-1:0] len_choices [10] = '{0, 1, 2, 3, 5, 8, 17, 31, 32, 63};
        int stop_at;
        int k;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        stop_at = items_sent + quota;
        k = $urandom_range(9);
        while (items_sent < stop_at)
        begin
            if ($urandom_range(4) == 0)
                write_length(LEN_W'($urandom_range(1, 32)));
            else
                write_length(len_choices[k]);
            k = (k + 1) % 10;
            repeat ($urandom_range(6, 14)) send_random_text();
        end
    endtask

    task automatic test_backpressure();
        write_length(1);
        send_load(0, 8'h55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ready_hold = 200;
        repeat (60) send_text($urandom_range(1) ? 8'h55 : $urandom_range(127), 1'b1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ready_hold = 0;
        items_sent = 0;
        results_checked = 0;
        error_count = 0;
        settings_used = 0;
        stall_cycles = 0;
        for (int j = 0; j < PATTERN_MAX_DEF; j++)
            pat_store[j] = '0;
        match_vec = '0;
        text_pos = '0;
        saturated = 1'b0;
        reported = 1'b0;
        cur_len = LEN_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // every store entry written before random texts read them
        for (int j = 0; j < PATTERN_MAX_DEF; j++)
            send_load(j, pick_symbol());
        test_random_traffic(23, 48, 560);
        test_random_traffic(48, 23, 560);
        test_random_traffic(0, 0, 560);
        test_backpressure();
        wait_idle();

        $display("%0d words sent, %0d results checked over %0d length settings",
                 items_sent, results_checked, settings_used);
        $display("input held back for %0d cycles under random and long output stalls",
                 stall_cycles);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("shift_and_substring_search_core regression: pass");
        else
            $display("shift_and_substring_search_core regression: fail");
        $finish;
    end

endmodule
